>>> hw/rtl/sei_pkg.sv
// ----------------------------------------------------------------------------
// SEI NAL unit builder package
// Shared constants, byte codes and the job record passed from front to back.
// ----------------------------------------------------------------------------
package sei_pkg;

    localparam int unsigned MAX_PAYLOAD = 4096;
    localparam int LEN_W  = 13;
    localparam int SIZE_W = $clog2(MAX_PAYLOAD + 18);
    localparam int QDEPTH = 2;
    localparam int QA_W   = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QC_W   = $clog2(QDEPTH + 1);

    localparam logic [1:0] CMD_START = 2'd0;
    localparam logic [1:0] CMD_BYTE  = 2'd1;
    localparam logic [1:0] CMD_CLOSE = 2'd2;

    localparam logic [7:0] BYTE_ZERO      = 8'h00;
    localparam logic [7:0] START_CODE_END = 8'h01;
    localparam logic [7:0] NAL_TYPE_SEI   = 8'h06;
    localparam logic [7:0] SEI_TYPE_UDU   = 8'h05;
    localparam logic [7:0] SIZE_FILL      = 8'hFF;
    localparam logic [7:0] MSG_DELIM      = 8'hFF;
    localparam logic [7:0] EPB_BYTE       = 8'h03;
    localparam logic [7:0] TRAIL_BYTE     = 8'h80;
    localparam int unsigned SIZE_STEP     = 255;
    localparam int unsigned SIZE_OFFSET   = 17;

    typedef enum logic [1:0] {
        JOB_MISUSE = 2'd0,
        JOB_START  = 2'd1,
        JOB_DATA   = 2'd2,
        JOB_CLOSE  = 2'd3
    } job_kind_t;

    typedef struct packed {
        job_kind_t         kind;
        logic              prefix;
        logic              tail;
        logic              ins_epb;
        logic [7:0]        data;
        logic [SIZE_W-1:0] size;
        logic [127:0]      uuid;
    } job_t;

endpackage

>>> hw/rtl/sei_queue.sv
// ----------------------------------------------------------------------------
// SEI job queue
// Short register queue that decouples the classifier from the byte emitter.
// ----------------------------------------------------------------------------
module sei_queue
    import sei_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_job,
    output logic full,
    input  logic pop,
    output job_t head_job,
    output logic empty
);

    job_t            slot_reg [QDEPTH];
    logic [QA_W-1:0] wptr_reg;
    logic [QA_W-1:0] wptr_next;
    logic [QA_W-1:0] rptr_reg;
    logic [QA_W-1:0] rptr_next;
    logic [QC_W-1:0] count_reg;
    logic [QC_W-1:0] count_next;

    assign full     = (count_reg == QC_W'(QDEPTH));
    assign empty    = (count_reg == '0);
    assign head_job = slot_reg[rptr_reg];

    always_comb
    begin
        wptr_next  = wptr_reg;
        rptr_next  = rptr_reg;
        count_next = count_reg;
        if (push)
        begin
            wptr_next = (wptr_reg == QA_W'(QDEPTH - 1)) ? '0 : wptr_reg + 1'b1;
        end
        if (pop)
        begin
            rptr_next = (rptr_reg == QA_W'(QDEPTH - 1)) ? '0 : rptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wptr_reg] <= push_job;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (!full || pop))
        else $error("Job pushed into a full queue.");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("Job popped from an empty queue.");

endmodule

>>> hw/rtl/sei_front.sv
// ----------------------------------------------------------------------------
// SEI front end
// Accepts input items, checks their order, tracks the unit and message state
// and turns each item into a job for the byte emitter.
// ----------------------------------------------------------------------------
module sei_front
    import sei_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    input  logic [1:0]   cmd,
    input  logic [12:0]  payload_length,
    input  logic [63:0]  uuid_high,
    input  logic [63:0]  uuid_low,
    input  logic [7:0]   payload_byte,
    output logic         push,
    output job_t         push_job,
    input  logic         full
);

    logic             unit_open_reg;
    logic             unit_open_next;
    logic             msg_open_reg;
    logic             msg_open_next;
    logic [LEN_W-1:0] bytes_left_reg;
    logic [LEN_W-1:0] bytes_left_next;
    logic [1:0]       zero_run_reg;
    logic [1:0]       zero_run_next;
    logic             accept;
    logic             too_long;
    logic             ins;
    logic [1:0]       run_base;
    logic [LEN_W-1:0] left_dec;

    assign in_ready = !full;
    assign accept   = in_valid && !full;
    assign too_long = (32'(payload_length) > MAX_PAYLOAD);
    assign ins      = (zero_run_reg == 2'd2) && (payload_byte <= EPB_BYTE);
    assign run_base = ins ? 2'd0 : zero_run_reg;
    assign left_dec = bytes_left_reg - 1'b1;

    always_comb
    begin
        unit_open_next  = unit_open_reg;
        msg_open_next   = msg_open_reg;
        bytes_left_next = bytes_left_reg;
        zero_run_next   = zero_run_reg;
        push            = 1'b0;
        push_job.kind   = JOB_MISUSE;
        push_job.prefix = !unit_open_reg;
        push_job.tail   = 1'b0;
        push_job.ins_epb = ins;
        push_job.data   = payload_byte;
        push_job.size   = SIZE_W'(payload_length) + SIZE_W'(SIZE_OFFSET);
        push_job.uuid   = {uuid_high, uuid_low};
        if (accept)
        begin
            push = 1'b1;
            case (cmd)
                CMD_START:
                begin
                    if (!msg_open_reg && !too_long)
                    begin
                        push_job.kind   = JOB_START;
                        push_job.tail   = (payload_length == '0);
                        unit_open_next  = 1'b1;
                        zero_run_next   = 2'd0;
                        msg_open_next   = (payload_length != '0);
                        bytes_left_next = payload_length;
                    end
                end
                CMD_BYTE:
                begin
                    if (msg_open_reg && bytes_left_reg != '0)
                    begin
                        push_job.kind   = JOB_DATA;
                        push_job.tail   = (left_dec == '0);
                        bytes_left_next = left_dec;
                        if (payload_byte == '0)
                        begin
                            zero_run_next = (run_base == 2'd2) ? 2'd2 : run_base + 1'b1;
                        end
                        else
                        begin
                            zero_run_next = 2'd0;
                        end
                        if (left_dec == '0)
                        begin
                            msg_open_next = 1'b0;
                            zero_run_next = 2'd0;
                        end
                    end
                end
                CMD_CLOSE:
                begin
                    if (!msg_open_reg)
                    begin
                        push           = unit_open_reg;
                        push_job.kind  = JOB_CLOSE;
                        unit_open_next = 1'b0;
                    end
                end
                default:
                begin
                    push_job.kind = JOB_MISUSE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            unit_open_reg  <= 1'b0;
            msg_open_reg   <= 1'b0;
            bytes_left_reg <= '0;
            zero_run_reg   <= '0;
        end
        else
        begin
            unit_open_reg  <= unit_open_next;
            msg_open_reg   <= msg_open_next;
            bytes_left_reg <= bytes_left_next;
            zero_run_reg   <= zero_run_next;
        end
    end

    a_msg_in_unit: assert property (@(posedge clk) disable iff (!rst_n)
        msg_open_reg |-> unit_open_reg)
        else $error("Message open outside of a unit.");

    a_open_has_bytes: assert property (@(posedge clk) disable iff (!rst_n)
        msg_open_reg |-> (bytes_left_reg != '0))
        else $error("Open message with no bytes left.");

endmodule

>>> hw/rtl/sei_back.sv
// ----------------------------------------------------------------------------
// SEI byte emitter
// Takes jobs from the queue and emits the encoded stream one byte per cycle,
// while the output accepts, into a registered output stage.
// ----------------------------------------------------------------------------
module sei_back
    import sei_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  job_t       head_job,
    input  logic       empty,
    output logic       pop,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte,
    output logic       run_last,
    output logic       unit_end,
    output logic       misuse
);

    typedef enum logic [6:0] {
        S_HEAD   = 7'b0000001,
        S_PREFIX = 7'b0000010,
        S_TYPE   = 7'b0000100,
        S_SIZE   = 7'b0001000,
        S_UUID   = 7'b0010000,
        S_DATA   = 7'b0100000,
        S_TAIL   = 7'b1000000
    } back_state_t;

    back_state_t       state_reg;
    back_state_t       state_next;
    logic [3:0]        cnt_reg;
    logic [3:0]        cnt_next;
    logic [SIZE_W-1:0] rem_reg;
    logic [SIZE_W-1:0] rem_next;
    logic              valid_reg;
    logic              valid_next;
    logic [7:0]        byte_reg;
    logic              last_reg;
    logic              end_reg;
    logic              bad_reg;
    logic              adv;
    logic              go;
    logic [7:0]        byte_c;
    logic              last_c;
    logic              end_c;
    logic              bad_c;

    assign adv       = !valid_reg || out_ready;
    assign go        = adv && !empty;
    assign out_valid = valid_reg;
    assign out_byte  = byte_reg;
    assign run_last  = last_reg;
    assign unit_end  = end_reg;
    assign misuse    = bad_reg;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        rem_next   = rem_reg;
        byte_c     = BYTE_ZERO;
        last_c     = 1'b0;
        end_c      = 1'b0;
        bad_c      = 1'b0;
        pop        = 1'b0;
        valid_next = valid_reg && !out_ready;
        if (go)
        begin
            valid_next = 1'b1;
            case (state_reg)
                S_HEAD:
                begin
                    case (head_job.kind)
                        JOB_MISUSE:
                        begin
                            bad_c  = 1'b1;
                            last_c = 1'b1;
                            pop    = 1'b1;
                        end
                        JOB_CLOSE:
                        begin
                            byte_c = TRAIL_BYTE;
                            end_c  = 1'b1;
                            last_c = 1'b1;
                            pop    = 1'b1;
                        end
                        JOB_DATA:
                        begin
                            if (head_job.ins_epb)
                            begin
                                byte_c     = EPB_BYTE;
                                state_next = S_DATA;
                            end
                            else
                            begin
                                byte_c = head_job.data;
                                if (head_job.tail)
                                begin
                                    state_next = S_TAIL;
                                end
                                else
                                begin
                                    last_c = 1'b1;
                                    pop    = 1'b1;
                                end
                            end
                        end
                        default:
                        begin
                            if (head_job.prefix)
                            begin
                                byte_c     = BYTE_ZERO;
                                cnt_next   = 4'd1;
                                state_next = S_PREFIX;
                            end
                            else
                            begin
                                byte_c     = SEI_TYPE_UDU;
                                rem_next   = head_job.size;
                                state_next = S_SIZE;
                            end
                        end
                    endcase
                end
                S_PREFIX:
                begin
                    cnt_next = cnt_reg + 1'b1;
                    if (cnt_reg == 4'd3)
                    begin
                        byte_c = START_CODE_END;
                    end
                    else if (cnt_reg == 4'd4)
                    begin
                        byte_c     = NAL_TYPE_SEI;
                        state_next = S_TYPE;
                    end
                    else
                    begin
                        byte_c = BYTE_ZERO;
                    end
                end
                S_TYPE:
                begin
                    byte_c     = SEI_TYPE_UDU;
                    rem_next   = head_job.size;
                    state_next = S_SIZE;
                end
                S_SIZE:
                begin
                    if (32'(rem_reg) > SIZE_STEP - 1)
                    begin
                        byte_c   = SIZE_FILL;
                        rem_next = rem_reg - SIZE_W'(SIZE_STEP);
                    end
                    else
                    begin
                        byte_c     = 8'(rem_reg);
                        cnt_next   = 4'd0;
                        state_next = S_UUID;
                    end
                end
                S_UUID:
                begin
                    byte_c   = head_job.uuid[{~cnt_reg, 3'b000} +: 8];
                    cnt_next = cnt_reg + 1'b1;
                    if (cnt_reg == 4'd15)
                    begin
                        if (head_job.tail)
                        begin
                            state_next = S_TAIL;
                        end
                        else
                        begin
                            last_c     = 1'b1;
                            pop        = 1'b1;
                            state_next = S_HEAD;
                        end
                    end
                end
                S_DATA:
                begin
                    byte_c = head_job.data;
                    if (head_job.tail)
                    begin
                        state_next = S_TAIL;
                    end
                    else
                    begin
                        last_c     = 1'b1;
                        pop        = 1'b1;
                        state_next = S_HEAD;
                    end
                end
                S_TAIL:
                begin
                    byte_c     = MSG_DELIM;
                    last_c     = 1'b1;
                    pop        = 1'b1;
                    state_next = S_HEAD;
                end
                default:
                begin
                    state_next = S_HEAD;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_HEAD;
            valid_reg <= 1'b0;
            cnt_reg   <= '0;
            rem_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
            cnt_reg   <= cnt_next;
            rem_reg   <= rem_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (go)
        begin
            byte_reg <= byte_c;
            last_reg <= last_c;
            end_reg  <= end_c;
            bad_reg  <= bad_c;
        end
    end

    a_misuse_form: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && bad_reg) |-> (last_reg && byte_reg == BYTE_ZERO && !end_reg))
        else $error("Misuse item is not a lone zero byte.");

    a_trail_form: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && end_reg) |-> (last_reg && byte_reg == TRAIL_BYTE))
        else $error("Unit end flag on a byte other than the trailing byte.");

    a_job_held: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_HEAD) |-> !empty)
        else $error("Emitter is inside a job but the queue is empty.");

    a_pop_marks_last: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> (valid_reg && last_reg))
        else $error("Job retired without a last item.");

endmodule

>>> hw/rtl/sei_nal_unit_builder_top.sv
// ----------------------------------------------------------------------------
// SEI NAL unit builder
// Streams an H.264 SEI NAL unit of unregistered user-data messages.
// ----------------------------------------------------------------------------
// Input items arrive on the s_axis group. tuser carries the command: start a
// message, one payload byte, or close the unit. A start item emits the start
// code and NAL type when no unit is open, then the payload type, the size
// field and the 16 UUID bytes. Payload items pass one byte each, with an
// emulation prevention byte inserted after two zeros when the next byte is
// at most 3, and the last byte of a message is followed by 0xFF. A close
// item emits 0x80, or nothing when no unit is open. Out-of-order, unknown or
// over-long items give one zero byte flagged as misuse.
// Result items leave on the m_axis group, one byte per cycle while m_axis_tready
// is high; tlast marks the last byte caused by an input item. An accepted item
// is written into a queue slot, and its first byte is then registered in the
// output stage. A payload item gives one to three output bytes, a start item up
// to 39; the output byte rate sets the throughput.
// A two-entry job queue lets the input keep accepting while the output is
// stalled, until the queue is full. Reset empties the queue, clears the
// output stage and closes any open unit and message.
// ----------------------------------------------------------------------------
module sei_nal_unit_builder_top
    import sei_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // payload_length[12:0], uuid_high[76:13], uuid_low[140:77],
    // payload_byte[148:141], zero fill[151:149]
    input  logic [151:0] s_axis_tdata,
    // cmd[1:0]
    input  logic [1:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // out_byte[7:0]
    output logic [7:0]   m_axis_tdata,
    output logic         m_axis_tlast,
    // unit_end[0], misuse[1]
    output logic [1:0]   m_axis_tuser
);

    logic push;
    job_t push_job;
    logic full;
    logic pop;
    job_t head_job;
    logic empty;

    sei_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (s_axis_tvalid),
        .in_ready       (s_axis_tready),
        .cmd            (s_axis_tuser),
        .payload_length (s_axis_tdata[12:0]),
        .uuid_high      (s_axis_tdata[76:13]),
        .uuid_low       (s_axis_tdata[140:77]),
        .payload_byte   (s_axis_tdata[148:141]),
        .push           (push),
        .push_job       (push_job),
        .full           (full)
    );

    sei_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .full     (full),
        .pop      (pop),
        .head_job (head_job),
        .empty    (empty)
    );

    sei_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head_job  (head_job),
        .empty     (empty),
        .pop       (pop),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_byte  (m_axis_tdata),
        .run_last  (m_axis_tlast),
        .unit_end  (m_axis_tuser[0]),
        .misuse    (m_axis_tuser[1])
    );

endmodule

>>> dv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// SEI NAL unit builder testbench
// Drives start, payload, close and unknown items into the builder and predicts the
// encoded byte stream: start code, SEI header, size field, UUID, payload
// bytes with emulation prevention, delimiters and trailing bytes. Every output
// byte is checked field by field. Directed cases come first. Random messages
// follow, with noise items and random stalls on both sides, one long output
// stall and one full drain.
// ----------------------------------------------------------------------------
module tb;
    import sei_pkg::*;

    localparam logic [1:0]  CMD_UNKNOWN   = 2'd3;
    localparam logic [7:0]  EPB_LIMIT     = 8'h03;
    localparam int unsigned ZERO_RUN_MAX  = 2;
    localparam int unsigned TOTAL_ITEMS   = 350;
    localparam int unsigned CALM_ITEMS    = 60;
    localparam int unsigned HOLD_CYCLES   = 400;
    localparam int unsigned TAIL_CYCLES   = 40;
    localparam int unsigned LIMIT_CYCLES  = 1000000;
    localparam int unsigned LONG_LENGTH   = 238;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       unit_end;
        logic       misuse;
    } nal_byte_t;

    class nal_stream_model;
        nal_byte_t   due_bytes[$];
        nal_byte_t   item_bytes[$];
        bit          unit_open = 1'b0;
        bit          msg_open = 1'b0;
        logic [12:0] bytes_left = '0;
        int unsigned zero_run = 0;
        int unsigned errors = 0;
        int unsigned items = 0;
        int unsigned bytes_seen = 0;
        int unsigned epb_count = 0;
        int unsigned misuse_count = 0;
        int unsigned msg_count = 0;
        int unsigned unit_count = 0;

        function void report(string what);
            errors++;
            $display("[%0t] mismatch: %s", $time, what);
        endfunction

        function void emit(logic [7:0] data, logic unit_end, logic misuse);
            nal_byte_t b;
            b.data = data;
            b.last = 1'b0;
            b.unit_end = unit_end;
            b.misuse = misuse;
            item_bytes.push_back(b);
        endfunction

        function void flag_misuse();
            emit(BYTE_ZERO, 1'b0, 1'b1);
            misuse_count++;
        endfunction

        function void predict_item(logic [1:0] cmd, logic [12:0] len, logic [127:0] uuid,
                                   logic [7:0] pb);
            int unsigned rem;
            nal_byte_t b;
            items++;
            item_bytes.delete();
            case (cmd)
                CMD_START:
                begin
                    if (msg_open || len > MAX_PAYLOAD) begin
                        flag_misuse();
                    end else begin
                        if (!unit_open) begin
                            emit(BYTE_ZERO, 1'b0, 1'b0);
                            emit(BYTE_ZERO, 1'b0, 1'b0);
                            emit(BYTE_ZERO, 1'b0, 1'b0);
                            emit(START_CODE_END, 1'b0, 1'b0);
                            emit(NAL_TYPE_SEI, 1'b0, 1'b0);
                            unit_open = 1'b1;
                        end
                        emit(SEI_TYPE_UDU, 1'b0, 1'b0);
                        rem = len + SIZE_OFFSET;
                        while (rem >= SIZE_STEP) begin
                            emit(SIZE_FILL, 1'b0, 1'b0);
                            rem -= SIZE_STEP;
                        end
                        emit(rem[7:0], 1'b0, 1'b0);
                        for (int i = 15; i >= 0; i--)
                            emit(uuid[i*8 +: 8], 1'b0, 1'b0);
                        zero_run = 0;
                        msg_count++;
                        if (len == 0) begin
                            emit(MSG_DELIM, 1'b0, 1'b0);
                            msg_open = 1'b0;
                            bytes_left = '0;
                        end else begin
                            msg_open = 1'b1;
                            bytes_left = len;
                        end
                    end
                end
                CMD_BYTE:
                begin
                    if (!msg_open || bytes_left == 0) begin
                        flag_misuse();
                    end else begin
                        if (zero_run >= ZERO_RUN_MAX && pb <= EPB_LIMIT) begin
                            emit(EPB_BYTE, 1'b0, 1'b0);
                            zero_run = 0;
                            epb_count++;
                        end
                        emit(pb, 1'b0, 1'b0);
                        if (pb == BYTE_ZERO) begin
                            if (zero_run < ZERO_RUN_MAX)
                                zero_run++;
                        end else begin
                            zero_run = 0;
                        end
                        bytes_left = bytes_left - 1'b1;
                        if (bytes_left == 0) begin
                            emit(MSG_DELIM, 1'b0, 1'b0);
                            msg_open = 1'b0;
                            zero_run = 0;
                        end
                    end
                end
                CMD_CLOSE:
                begin
                    if (msg_open) begin
                        flag_misuse();
                    end else if (unit_open) begin
                        emit(TRAIL_BYTE, 1'b1, 1'b0);
                        unit_open = 1'b0;
                        unit_count++;
                    end
                end
                default:
                begin
                    flag_misuse();
                end
            endcase
            for (int i = 0; i < item_bytes.size(); i++) begin
                b = item_bytes[i];
                b.last = (i == item_bytes.size() - 1);
                due_bytes.push_back(b);
            end
        endfunction

        function void check_byte(logic [7:0] data, logic last, logic [1:0] user);
            nal_byte_t exp_b;
            bytes_seen++;
            if (due_bytes.size() == 0) begin
                report($sformatf("byte %02h last %0b user %02b with nothing expected",
                                 data, last, user));
            end else begin
                exp_b = due_bytes.pop_front();
                if (data !== exp_b.data || last !== exp_b.last ||
                    user[0] !== exp_b.unit_end || user[1] !== exp_b.misuse)
                    report($sformatf({"byte %0d: got data %02h last %0b end %0b misuse %0b,",
                                      " expected %02h %0b %0b %0b"},
                                     bytes_seen, data, last, user[0], user[1],
                                     exp_b.data, exp_b.last, exp_b.unit_end, exp_b.misuse));
            end
        endfunction

        function void final_check();
            if (due_bytes.size() != 0)
                report($sformatf("%0d expected bytes never arrived", due_bytes.size()));
        endfunction
    endclass

    logic         clk = 1'b0;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [151:0] s_axis_tdata;
    logic [1:0]   s_axis_tuser;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [7:0]   m_axis_tdata;
    logic         m_axis_tlast;
    logic [1:0]   m_axis_tuser;

    nal_stream_model stream = new;
    bit              src_gaps;
    bit              sink_gaps;
    bit              hold_req;
    int unsigned     items_offered;
    int unsigned     cycles;

    sei_nal_unit_builder_top uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT_CYCLES) begin
            $display("Timeout after %0d cycles.", cycles);
            $display("FAIL sei_nal_unit_builder_top");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && s_axis_tvalid && s_axis_tready)
            stream.predict_item(s_axis_tuser, s_axis_tdata[12:0],
                                {s_axis_tdata[76:13], s_axis_tdata[140:77]},
                                s_axis_tdata[148:141]);
        if (rst_n && m_axis_tvalid && m_axis_tready)
            stream.check_byte(m_axis_tdata, m_axis_tlast, m_axis_tuser);
    end

    initial
    begin
        forever begin
            if (hold_req) begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end else if (sink_gaps && $urandom_range(0, 3) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge clk);
            end else begin
                m_axis_tready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    task automatic send_item(input logic [1:0] cmd, input logic [12:0] len,
                             input logic [63:0] hi, input logic [63:0] lo,
                             input logic [7:0] pb);
        if (src_gaps && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {3'b000, pb, lo, hi, len};
        items_offered++;
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (stream.due_bytes.size() != 0) @(posedge clk);
    endtask

    function automatic logic [7:0] pick_payload();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r < 4)
            return BYTE_ZERO;
        else if (r < 6)
            return 8'($urandom_range(1, 3));
        else if (r == 6)
            return 8'h04;
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic send_noise_outside();
        case ($urandom_range(0, 2))
            0: send_item(CMD_BYTE, 13'($urandom), {$urandom, $urandom}, {$urandom, $urandom},
                         8'($urandom));
            1: send_item(CMD_UNKNOWN, 13'($urandom), {$urandom, $urandom},
                         {$urandom, $urandom}, 8'($urandom));
            default: send_item(CMD_START, 13'($urandom_range(MAX_PAYLOAD + 1, 8191)),
                               {$urandom, $urandom}, {$urandom, $urandom}, 8'($urandom));
        endcase
    endtask

    task automatic send_noise_inside();
        case ($urandom_range(0, 2))
            0: send_item(CMD_START, 13'($urandom), {$urandom, $urandom},
                         {$urandom, $urandom}, 8'($urandom));
            1: send_item(CMD_CLOSE, 13'($urandom), {$urandom, $urandom},
                         {$urandom, $urandom}, 8'($urandom));
            default: send_item(CMD_UNKNOWN, 13'($urandom), {$urandom, $urandom},
                               {$urandom, $urandom}, 8'($urandom));
        endcase
    endtask

    initial
    begin
        logic [7:0]  epb_seq[$];
        int unsigned msg_len;
        bit          long_done;
        bit          hold_done;
        bit          drain_done;

        epb_seq = '{8'h00, 8'h00, 8'h04, 8'h00, 8'h00, 8'h03, 8'h00, 8'h00, 8'h00};
        long_done = 1'b0;
        hold_done = 1'b0;
        drain_done = 1'b0;
        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= CMD_START;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_item(CMD_CLOSE, '0, '0, '0, '0);
        send_item(CMD_BYTE, '0, '0, '0, 8'hFF);
        send_item(CMD_UNKNOWN, '1, '1, '1, '1);
        send_item(CMD_START, 13'd8191, '1, '1, '0);
        send_item(CMD_START, '0, '0, '0, '0);
        send_item(CMD_START, 13'(MAX_PAYLOAD + 1), '0, '0, '0);
        send_item(CMD_START, 13'd1, '1, '1, '0);
        send_item(CMD_BYTE, '0, '0, '0, 8'hFF);
        send_item(CMD_CLOSE, '0, '0, '0, '0);
        send_item(CMD_CLOSE, '0, '0, '0, '0);
        send_item(CMD_START, 13'(epb_seq.size()), {$urandom, $urandom}, {$urandom, $urandom},
                  '0);
        send_item(CMD_START, 13'd5, '0, '0, '0);
        send_item(CMD_CLOSE, '0, '0, '0, '0);
        send_item(CMD_UNKNOWN, '0, '0, '0, '0);
        foreach (epb_seq[i])
            send_item(CMD_BYTE, '0, '0, '0, epb_seq[i]);
        send_item(CMD_BYTE, '0, '0, '0, 8'h00);
        send_item(CMD_CLOSE, '0, '0, '0, '0);

        while (items_offered < TOTAL_ITEMS) begin
            if (items_offered + CALM_ITEMS > TOTAL_ITEMS) begin
                src_gaps = 1'b0;
                sink_gaps = 1'b0;
            end else begin
                src_gaps = ($urandom_range(0, 3) != 0);
                sink_gaps = ($urandom_range(0, 3) != 0);
            end
            if (!hold_done && items_offered >= 40) begin
                hold_req = 1'b1;
                hold_done = 1'b1;
            end
            if (!drain_done && items_offered >= 200) begin
                wait_drained();
                drain_done = 1'b1;
            end
            if ($urandom_range(0, 3) == 0)
                repeat ($urandom_range(1, 2)) send_noise_outside();
            if ($urandom_range(0, 3) == 0)
                send_item(CMD_CLOSE, 13'($urandom), {$urandom, $urandom},
                          {$urandom, $urandom}, 8'($urandom));
            if (!long_done && items_offered >= 45) begin
                msg_len = LONG_LENGTH;
                long_done = 1'b1;
            end else begin
                case ($urandom_range(0, 19))
                    0: msg_len = 0;
                    17, 18, 19: msg_len = $urandom_range(9, 40);
                    default: msg_len = $urandom_range(1, 8);
                endcase
            end
            send_item(CMD_START, 13'(msg_len), {$urandom, $urandom}, {$urandom, $urandom},
                      8'($urandom));
            for (int k = 0; k < msg_len; k++) begin
                if ($urandom_range(0, 11) == 0)
                    send_noise_inside();
                send_item(CMD_BYTE, 13'($urandom), {$urandom, $urandom},
                          {$urandom, $urandom}, pick_payload());
            end
        end

        send_item(CMD_CLOSE, '0, '0, '0, '0);
        send_item(CMD_START, 13'(MAX_PAYLOAD), {$urandom, $urandom}, {$urandom, $urandom},
                  '0);
        repeat (5) send_item(CMD_BYTE, '0, '0, '0, pick_payload());
        send_item(CMD_CLOSE, '0, '0, '0, '0);
        send_item(CMD_START, 13'd3, '0, '0, '0);

        s_axis_tvalid <= 1'b0;
        while (stream.due_bytes.size() != 0) @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        stream.final_check();
        $display("Run covered %0d input items and %0d output bytes, %0d messages, %0d units.",
                 stream.items, stream.bytes_seen, stream.msg_count, stream.unit_count);
        $display("Inserted %0d emulation prevention bytes and flagged %0d misuse items.",
                 stream.epb_count, stream.misuse_count);
        if (stream.errors == 0)
            $display("PASS sei_nal_unit_builder_top");
        else
            $display("FAIL sei_nal_unit_builder_top");
        $finish;
    end

endmodule

>>> filelist.f
hw/rtl/sei_pkg.sv
hw/rtl/sei_queue.sv
hw/rtl/sei_front.sv
hw/rtl/sei_back.sv
hw/rtl/sei_nal_unit_builder_top.sv
dv/tb.sv
